// ----- hdl/ges_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ges_pkg: shared types and constants of the linear-system solver
// Sizes, fixed-point helpers and controller/datapath command types.
// ---------------------------------------------------------------------------
package ges_pkg;
  localparam int Unknowns = 3;
  localparam int FracBits = 16;
  localparam int Cols = Unknowns + 1;
  localparam int Entries = Unknowns * Cols;
  localparam int RW = $clog2(Unknowns);
  localparam int CW = $clog2(Cols);
  localparam int AW = $clog2(Entries);
  localparam int LW = $clog2(Entries + 1);
  localparam int DivSteps = 32 + FracBits + 1;
  localparam int DSW = $clog2(DivSteps + 1);

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ELIM = 2'd1,
    OP_BACK = 2'd2
  } op_t;

  // command from controller to datapath
  typedef struct packed {
    logic          rd;      // read a word
    logic [AW-1:0] rd_addr;
    logic          wr_mac;  // write back saturated accumulator
    logic          wr_swap; // write swap register
    logic [AW-1:0] wr_addr;
    logic          ld_swap; // latch read word into swap register
    logic          ld_a;    // latch read word into multiplier operand a
    logic          ld_b;    // latch read word as operand b
    logic          ld_b_x;  // operand b from solution store
    logic [RW-1:0] x_idx;
    logic          mul;     // accumulate acc - a*b
    logic          acc_ld;  // acc = read word
    logic          div_go;  // start acc / divisor
    logic          ld_div;  // latch read word as divisor
    logic          m_ld;    // multiplier reg = quotient
    logic          a_is_m;  // operand a = multiplier reg
    logic          x_wr;    // solution store[x_idx] = quotient
    logic          zero_wr; // write zero at wr_addr
  } cmd_t;

  typedef struct packed {
    logic          rd_zero; // last read word is zero
    logic          div_busy;
  } sts_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fffffff;
    if (v < -66'sd2147483648) return 32'h80000000;
    return v[31:0];
  endfunction
endpackage

// ----- hdl/ges_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ges_div: serial fixed-point divider
// Computes sat(trunc(a*2^F / b)), one quotient bit per cycle.
// ---------------------------------------------------------------------------
module ges_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        go,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        busy,
  output logic [31:0] quo
);
  import ges_pkg::*;

  localparam int NW = 32 + FracBits;

  logic [NW-1:0]  n_r, n_nxt;
  logic [32:0]    rem_r, rem_nxt;
  logic [NW:0]    q_r, q_nxt;
  logic [31:0]    d_r, d_nxt;
  logic           neg_r, neg_nxt;
  logic [DSW-1:0] cnt_r, cnt_nxt;
  logic [31:0]    quo_r, quo_nxt;
  logic           busy_r, busy_nxt;
  logic [32:0]    sh;
  logic signed [NW+1:0] sq;
  logic [NW-1:0]  an;

  assign busy = busy_r;
  assign quo = quo_r;

  always_comb begin
    n_nxt = n_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    d_nxt = d_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    quo_nxt = quo_r;
    busy_nxt = busy_r;
    an = {(num[31] ? (~num + 32'd1) : num), {FracBits{1'b0}}};
    sh = {rem_r[31:0], n_r[NW-1]};
    sq = '0;
    if (go) begin
      n_nxt = an;
      d_nxt = den[31] ? (~den + 32'd1) : den;
      neg_nxt = num[31] ^ den[31];
      rem_nxt = '0;
      q_nxt = '0;
      cnt_nxt = DSW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        n_nxt = {n_r[NW-2:0], 1'b0};
        if (sh >= {1'b0, d_r}) begin
          rem_nxt = sh - {1'b0, d_r};
          q_nxt = {q_r[NW-1:0], 1'b1};
        end else begin
          rem_nxt = sh;
          q_nxt = {q_r[NW-1:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
      end else begin
        sq = neg_r ? -$signed({2'b00, q_r[NW-1:0]}) : $signed({2'b00, q_r[NW-1:0]});
        quo_nxt = sat32(66'(sq));
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
    quo_r <= quo_nxt;
  end
endmodule

// ----- hdl/ges_datapath.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ges_datapath: matrix store, multiply-accumulate and divider
// Executes controller commands on the augmented matrix and solution store.
// ---------------------------------------------------------------------------
module ges_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_wr,
  input  logic [ges_pkg::AW-1:0] in_addr,
  input  logic [31:0]        in_data,
  input  ges_pkg::cmd_t      cmd,
  output ges_pkg::sts_t      sts,
  output logic [31:0]        x_word
);
  import ges_pkg::*;

  logic [31:0] mem [Entries];
  logic [31:0] xs [Unknowns];
  logic [31:0] rd_r, swap_r, a_r, b_r, m_r, den_r;
  logic signed [65:0] acc_r;
  logic signed [63:0] prod_r;
  logic        prod_v_r;
  logic        div_busy;
  logic [31:0] quo;
  logic signed [63:0] p, pb;

  assign x_word = xs[cmd.x_idx];
  assign sts.rd_zero = (rd_r == '0);
  assign sts.div_busy = div_busy | prod_v_r;

  always_ff @(posedge clk) begin
    if (in_wr) mem[in_addr] <= in_data;
    else if (cmd.wr_mac) mem[cmd.wr_addr] <= sat32(acc_r);
    else if (cmd.wr_swap) mem[cmd.wr_addr] <= swap_r;
    else if (cmd.zero_wr) mem[cmd.wr_addr] <= '0;
    if (cmd.rd) rd_r <= mem[cmd.rd_addr];
  end

  // truncate toward zero: bias negative products before the shift
  always_comb begin
    p = $signed(a_r) * $signed(b_r);
    pb = p + (p[63] ? ((64'sd1 <<< FracBits) - 64'sd1) : 64'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) prod_v_r <= 1'b0;
    else prod_v_r <= cmd.mul;
    if (cmd.ld_swap) swap_r <= rd_r;
    if (cmd.ld_a) a_r <= cmd.a_is_m ? m_r : rd_r;
    if (cmd.ld_b) b_r <= cmd.ld_b_x ? xs[cmd.x_idx] : rd_r;
    if (cmd.ld_div) den_r <= rd_r;
    if (cmd.m_ld) m_r <= quo;
    if (cmd.x_wr) xs[cmd.x_idx] <= quo;
    if (cmd.mul) prod_r <= pb >>> FracBits;
    if (cmd.acc_ld) acc_r <= 66'($signed(rd_r));
    else if (prod_v_r) acc_r <= acc_r - 66'(prod_r);
  end

  ges_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (cmd.div_go),
    .num  (cmd.m_ld | cmd.x_wr ? 32'd0 : sat32(acc_r)),
    .den  (den_r),
    .busy (div_busy),
    .quo  (quo)
  );
endmodule

// ----- hdl/ges_ctrl.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ges_ctrl: solver sequencer
// Loads words, runs pivot search, swap, elimination and back substitution.
// ---------------------------------------------------------------------------
module ges_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                in_wr,
  output logic [ges_pkg::AW-1:0] in_addr,
  output ges_pkg::cmd_t       cmd,
  input  ges_pkg::sts_t       sts,
  input  logic [31:0]         x_word,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_solution,
  output logic [2:0]          out_unknown_index,
  output logic                out_status,
  output logic                out_last
);
  import ges_pkg::*;

  typedef enum logic [15:0] {
    S_LOAD   = 16'h0001,
    S_PRD    = 16'h0002,
    S_PCHK   = 16'h0004,
    S_SWRD   = 16'h0008,
    S_SWA    = 16'h0010,
    S_SWB    = 16'h0020,
    S_MRD    = 16'h0040,
    S_MDIV   = 16'h0080,
    S_MWAIT  = 16'h0100,
    S_URD    = 16'h0200,
    S_UMUL   = 16'h0400,
    S_UWB    = 16'h0800,
    S_BRD    = 16'h1000,
    S_BMAC   = 16'h2000,
    S_BDIV   = 16'h4000,
    S_OUT    = 16'h8000
  } state_t;

  state_t state_r, state_nxt;
  logic [LW-1:0] ld_r, ld_nxt;
  logic [RW-1:0] i_r, i_nxt, j_r, j_nxt, p_r, p_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [2:0]    ph_r, ph_nxt;
  logic          fail_r, fail_nxt;

  function automatic logic [AW-1:0] ad(input logic [RW-1:0] r, input logic [CW-1:0] c);
    return AW'(r * Cols + c);
  endfunction

  assign in_ready = (state_r == S_LOAD);
  assign in_wr = in_valid && in_ready;
  assign in_addr = ld_r[AW-1:0];
  assign out_valid = (state_r == S_OUT);
  assign out_status = fail_r;
  assign out_solution = fail_r ? 32'd0 : x_word;
  assign out_unknown_index = fail_r ? 3'd0 : 3'(i_r);
  assign out_last = fail_r || (i_r == RW'(Unknowns - 1));

  always_comb begin
    state_nxt = state_r;
    ld_nxt = ld_r;
    i_nxt = i_r; j_nxt = j_r; p_nxt = p_r; k_nxt = k_r;
    ph_nxt = ph_r;
    fail_nxt = fail_r;
    cmd = '0;
    cmd.x_idx = (state_r == S_OUT) ? i_r : k_r[RW-1:0];
    case (state_r)
      S_LOAD: begin
        if (in_wr) begin
          if (ld_r == LW'(Entries - 1)) begin
            ld_nxt = '0;
            i_nxt = '0;
            p_nxt = '0;
            fail_nxt = 1'b0;
            state_nxt = S_PRD;
          end else ld_nxt = ld_r + 1'b1;
        end
      end
      S_PRD: begin
        cmd.rd = 1'b1;
        cmd.rd_addr = ad(p_r, CW'(i_r));
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (!sts.rd_zero) begin
          k_nxt = '0;
          ph_nxt = '0;
          if (p_r == i_r) begin
            j_nxt = i_r + 1'b1;
            state_nxt = (i_r == RW'(Unknowns - 1)) ? S_BRD : S_MRD;
            if (i_r == RW'(Unknowns - 1)) begin
              i_nxt = i_r; k_nxt = CW'(Unknowns); ph_nxt = '0;
            end
          end else state_nxt = S_SWRD;
        end else if (p_r == RW'(Unknowns - 1) || i_r == RW'(Unknowns - 1)) begin
          fail_nxt = 1'b1;
          i_nxt = '0;
          state_nxt = S_OUT;
        end else begin
          p_nxt = p_r + 1'b1;
          state_nxt = S_PRD;
        end
      end
      S_SWRD: begin
        cmd.rd = 1'b1;
        cmd.rd_addr = ad(p_r, k_r);
        state_nxt = S_SWA;
      end
      S_SWA: begin
        cmd.ld_swap = 1'b1;
        cmd.rd = 1'b1;
        cmd.rd_addr = ad(i_r, k_r);
        state_nxt = S_SWB;
      end
      S_SWB: begin
        // rd holds row i word, swap holds row p word
        cmd.wr_swap = 1'b1;
        cmd.wr_addr = ad(i_r, k_r);
        cmd.acc_ld = 1'b1;
        cmd.ld_swap = 1'b1;
        if (ph_r == 3'd0) begin
          ph_nxt = 3'd1;
        end else begin
          cmd.wr_swap = 1'b1;
          cmd.wr_addr = ad(p_r, k_r);
          ph_nxt = 3'd0;
          if (k_r == CW'(Cols - 1)) begin
            j_nxt = i_r + 1'b1;
            k_nxt = '0;
            state_nxt = S_MRD;
          end else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_SWRD;
          end
        end
      end
      S_MRD: begin
        cmd.rd = 1'b1;
        if (ph_r == 3'd0) begin
          cmd.rd_addr = ad(i_r, CW'(i_r));
          ph_nxt = 3'd1;
        end else begin
          cmd.ld_div = 1'b1;
          cmd.rd_addr = ad(j_r, CW'(i_r));
          ph_nxt = 3'd2;
          state_nxt = S_MDIV;
        end
      end
      S_MDIV: begin
        cmd.acc_ld = 1'b1;
        ph_nxt = 3'd0;
        state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        if (ph_r == 3'd0) begin
          cmd.div_go = 1'b1;
          ph_nxt = 3'd1;
        end else if (!sts.div_busy) begin
          cmd.m_ld = 1'b1;
          cmd.zero_wr = 1'b1;
          cmd.wr_addr = ad(j_r, CW'(i_r));
          k_nxt = CW'(i_r) + 1'b1;
          ph_nxt = 3'd0;
          state_nxt = S_URD;
        end
      end
      S_URD: begin
        cmd.rd = 1'b1;
        if (ph_r == 3'd0) begin
          cmd.rd_addr = ad(i_r, k_r);
          ph_nxt = 3'd1;
        end else begin
          cmd.rd_addr = ad(j_r, k_r);
          cmd.ld_b = 1'b1;
          cmd.ld_a = 1'b1;
          cmd.a_is_m = 1'b1;
          ph_nxt = 3'd0;
          state_nxt = S_UMUL;
        end
      end
      S_UMUL: begin
        cmd.acc_ld = 1'b1;
        cmd.mul = 1'b1;
        state_nxt = S_UWB;
      end
      S_UWB: begin
        if (!sts.div_busy) begin
          cmd.wr_mac = 1'b1;
          cmd.wr_addr = ad(j_r, k_r);
          if (k_r != CW'(Cols - 1)) begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_URD;
          end else if (j_r != RW'(Unknowns - 1)) begin
            j_nxt = j_r + 1'b1;
            state_nxt = S_MRD;
          end else begin
            i_nxt = i_r + 1'b1;
            p_nxt = i_r + 1'b1;
            state_nxt = S_PRD;
          end
        end
      end
      S_BRD: begin
        // ph0: read rhs into acc, then per k: read A[i][k], mul with x[k]
        cmd.rd = 1'b1;
        if (ph_r == 3'd0) begin
          cmd.rd_addr = ad(i_r, CW'(Unknowns));
          ph_nxt = 3'd1;
        end else if (ph_r == 3'd1) begin
          cmd.acc_ld = 1'b1;
          k_nxt = CW'(i_r) + 1'b1;
          cmd.rd_addr = ad(i_r, CW'(i_r) + 1'b1);
          ph_nxt = 3'd2;
          if (i_r == RW'(Unknowns - 1)) begin
            cmd.rd_addr = ad(i_r, CW'(i_r));
            ph_nxt = 3'd4;
          end
        end else if (ph_r == 3'd2) begin
          cmd.rd = 1'b0;
          cmd.ld_a = 1'b1;
          cmd.ld_b = 1'b1;
          cmd.ld_b_x = 1'b1;
          ph_nxt = 3'd3;
          state_nxt = S_BMAC;
        end else if (ph_r == 3'd4) begin
          cmd.rd = 1'b0;
          cmd.ld_div = 1'b1;
          state_nxt = S_BDIV;
          ph_nxt = 3'd0;
        end else begin
          cmd.rd_addr = ad(i_r, k_r);
          ph_nxt = 3'd2;
        end
      end
      S_BMAC: begin
        cmd.mul = 1'b1;
        state_nxt = S_BMAC;
        ph_nxt = 3'd5;
        if (ph_r == 3'd5 && !sts.div_busy) begin
          if (k_r == CW'(Unknowns - 1)) begin
            cmd.rd = 1'b1;
            cmd.mul = 1'b0;
            cmd.rd_addr = ad(i_r, CW'(i_r));
            ph_nxt = 3'd4;
            state_nxt = S_BRD;
          end else begin
            cmd.mul = 1'b0;
            k_nxt = k_r + 1'b1;
            ph_nxt = 3'd6;
            state_nxt = S_BRD;
          end
        end else if (ph_r == 3'd5) cmd.mul = 1'b0;
      end
      S_BDIV: begin
        if (ph_r == 3'd0) begin
          cmd.div_go = 1'b1;
          ph_nxt = 3'd1;
        end else if (!sts.div_busy) begin
          cmd.x_wr = 1'b1;
          cmd.x_idx = i_r;
          ph_nxt = 3'd0;
          if (i_r == '0) begin
            state_nxt = S_OUT;
          end else begin
            i_nxt = i_r - 1'b1;
            state_nxt = S_BRD;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (out_last) state_nxt = S_LOAD;
          else i_nxt = i_r + 1'b1;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
    // final diagonal zero check happens in S_BDIV setup
    if (state_r == S_BRD && ph_r == 3'd4 && i_r == RW'(Unknowns - 1) && sts.rd_zero) begin
      fail_nxt = 1'b1;
      i_nxt = '0;
      state_nxt = S_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      ld_r <= '0;
      fail_r <= 1'b0;
      i_r <= '0;
      ph_r <= '0;
    end else begin
      state_r <= state_nxt;
      ld_r <= ld_nxt;
      fail_r <= fail_nxt;
      i_r <= i_nxt;
      ph_r <= ph_nxt;
    end
    j_r <= j_nxt;
    p_r <= p_nxt;
    k_r <= k_nxt;
  end
endmodule

// ----- hdl/gaussian_elimination_solver.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_elimination_solver: fixed-point N x N linear system solver
// Loads the augmented matrix, eliminates with first-nonzero pivoting,
// back-substitutes and emits the solution vector.
//
//   channel | ports                                  | dir
//   in      | in_valid, in_ready, in_coefficient     | in
//   out     | out_valid, out_ready, out_solution,    | out
//           | out_unknown_index, out_status, out_last|
//
// One word per cycle while loading. The solve then runs a shared serial
// divider (N(N-1)/2 + N divisions) and one multiplier for the
// multiply-subtract steps. Input is held off until
// all results of a system are taken. Reset: rst_n, synchronous, low.
// ---------------------------------------------------------------------------
module gaussian_elimination_solver (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_coefficient,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_solution,
  output logic [2:0]  out_unknown_index,
  output logic        out_status,
  output logic        out_last
);
  import ges_pkg::*;

  cmd_t          cmd;
  sts_t          sts;
  logic          in_wr;
  logic [AW-1:0] in_addr;
  logic [31:0]   x_word;

  ges_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_wr            (in_wr),
    .in_addr          (in_addr),
    .cmd              (cmd),
    .sts              (sts),
    .x_word           (x_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_solution     (out_solution),
    .out_unknown_index(out_unknown_index),
    .out_status       (out_status),
    .out_last         (out_last)
  );

  ges_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_wr  (in_wr),
    .in_addr(in_addr),
    .in_data(in_coefficient),
    .cmd    (cmd),
    .sts    (sts),
    .x_word (x_word)
  );
endmodule

// ----- tb/gaussian_elimination_solver_chk.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_elimination_solver_chk: result checker for the linear-system solver
// Collects accepted coefficient words, computes the expected solution words
// when a system is complete and compares every accepted result word with them.
// ---------------------------------------------------------------------------
module gaussian_elimination_solver_chk (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [31:0] in_coefficient,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_solution,
  input  logic [2:0]  out_unknown_index,
  input  logic        out_status,
  input  logic        out_last,
  output int          errors,
  output int          pending,
  output int          results_seen
);
  import ges_pkg::*;

  typedef struct packed {
    logic [31:0] solution;
    logic [2:0]  index;
    logic        status;
    logic        last;
  } sol_word_t;

  sol_word_t expected_q[$];
  logic signed [31:0] mat[Unknowns][Cols];
  logic signed [31:0] xs[Unknowns];
  int fill;

  function automatic logic signed [31:0] clamp(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'sh7fffffff;
    if (v < -66'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return p / (64'sd1 <<< FracBits);
  endfunction

  function automatic logic signed [31:0] qdiv(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    logic signed [65:0] n;
    n = 66'(a) * (66'sd1 <<< FracBits);
    return clamp(n / 66'(b));
  endfunction

  task automatic solve_system();
    int p;
    logic signed [31:0] t, m;
    logic signed [65:0] s;
    sol_word_t w;
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < Unknowns - 1 && ok; i++) begin
      p = -1;
      for (int j = i; j < Unknowns; j++)
        if (p < 0 && mat[j][i] != 0) p = j;
      if (p < 0) ok = 1'b0;
      else begin
        if (p != i)
          for (int k = 0; k < Cols; k++) begin
            t = mat[p][k]; mat[p][k] = mat[i][k]; mat[i][k] = t;
          end
        for (int j = i + 1; j < Unknowns; j++) begin
          m = qdiv(mat[j][i], mat[i][i]);
          for (int k = i + 1; k < Cols; k++)
            mat[j][k] = clamp(66'(mat[j][k]) - 66'(qmul(m, mat[i][k])));
          mat[j][i] = 0;
        end
      end
    end
    if (ok && mat[Unknowns-1][Unknowns-1] == 0) ok = 1'b0;
    if (!ok) begin
      w = '{solution: '0, index: '0, status: 1'b1, last: 1'b1};
      expected_q.push_back(w);
      return;
    end
    for (int i = Unknowns - 1; i >= 0; i--) begin
      s = 0;
      for (int k = i + 1; k < Unknowns; k++) s += 66'(qmul(mat[i][k], xs[k]));
      xs[i] = qdiv(clamp(66'(mat[i][Unknowns]) - s), mat[i][i]);
    end
    for (int i = 0; i < Unknowns; i++) begin
      w = '{solution: xs[i], index: 3'(i), status: 1'b0, last: i == Unknowns - 1};
      expected_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    sol_word_t e;
    if (!rst_n) begin
      fill <= 0;
      errors = 0;
      results_seen = 0;
    end else begin
      if (in_valid && in_ready) begin
        mat[fill / Cols][fill % Cols] = in_coefficient;
        if (fill == Entries - 1) begin
          fill <= 0;
          solve_system();
        end else begin
          fill <= fill + 1;
        end
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word sol=%h idx=%0d st=%0b last=%0b", $time,
                   out_solution, out_unknown_index, out_status, out_last);
        end else begin
          e = expected_q.pop_front();
          if (e != {out_solution, out_unknown_index, out_status, out_last}) begin
            errors++;
            $display("%0t: mismatch exp sol=%h idx=%0d st=%0b last=%0b", $time,
                     e.solution, e.index, e.status, e.last);
            $display("%0t:          got sol=%h idx=%0d st=%0b last=%0b", $time,
                     out_solution, out_unknown_index, out_status, out_last);
          end
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ----- tb/gaussian_elimination_solver_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// gaussian_elimination_solver_tb: top-level testbench of the solver
// Feeds directed and random augmented matrices with random gaps, stalls the
// result side at random and reports the checker's verdict.
// ---------------------------------------------------------------------------
module gaussian_elimination_solver_tb;
  import ges_pkg::*;

  localparam logic [31:0] One = 32'h0001_0000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] in_coefficient = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_solution;
  logic [2:0]  out_unknown_index;
  logic        out_status;
  logic        out_last;
  int          errors, pending, results_seen, systems;
  logic        stall_en = 1'b1;

  always #1 clk = ~clk;

  gaussian_elimination_solver dut (.*);

  gaussian_elimination_solver_chk chk (.*);

  task automatic send_word(input logic [31:0] v);
    int gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_coefficient <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // one augmented matrix, row-major
  task automatic send_system(input logic [31:0] m[Entries]);
    for (int i = 0; i < Entries; i++) send_word(m[i]);
    systems++;
  endtask

  function automatic logic [31:0] rand_word(input int kind);
    case (kind)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
      2: return 32'h0;
      default: return ($urandom_range(0, 1)) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  initial begin
    int idle_n;
    forever begin
      idle_n = stall_en ? $urandom_range(0, 6) : 0;
      if (idle_n != 0) begin
        out_ready <= 1'b0;
        repeat (idle_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] m[Entries];
    int kind;
    systems = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // identity
    m = '{One, 0, 0, One, 0, One, 0, 32'hfffe_0000, 0, 0, One, 32'h0003_8000};
    send_system(m);
    // pivot swap needed: first column zero on top
    m = '{0, One, 0, One, One, 0, 0, 32'h0002_0000, 0, 0, One, One};
    send_system(m);
    // singular: zero column
    m = '{0, One, 0, One, 0, 0, One, One, 0, One, One, 0};
    send_system(m);
    // saturating extremes
    m = '{1, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1,
          32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1, 32'h80000000};
    send_system(m);
    // drain fully before continuing
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
    stall_en = 1'b0;
    while (systems < 9) begin
      kind = $urandom_range(0, 9);
      for (int i = 0; i < Entries; i++) begin
        if (kind < 6) m[i] = rand_word(1);
        else if (kind < 8) m[i] = rand_word($urandom_range(0, 3));
        else m[i] = rand_word(($urandom_range(0, 2) == 0) ? 2 : 1);
      end
      if (systems == 6) stall_en = 1'b1;
      send_system(m);
    end
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d systems (%0d words), %0d result words checked.", systems,
             systems * Entries, results_seen);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule

// ----- filelist.f -----
hdl/ges_pkg.sv
hdl/ges_div.sv
hdl/ges_datapath.sv
hdl/ges_ctrl.sv
hdl/gaussian_elimination_solver.sv
tb/gaussian_elimination_solver_chk.sv
tb/gaussian_elimination_solver_tb.sv
